// ===== sv/svt_pkg.sv =====
`default_nettype none

package svt_pkg;

   localparam int ROT_W = 34;
   localparam int ATAN_COUNT = 24;

   localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [31:0] ATAN_TURN [ATAN_COUNT] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef struct packed {
      logic                    flip;
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ROT_W-1:0] z;
   } rotor_type;

endpackage

`default_nettype wire

// ===== sv/svt_channels.sv =====
`default_nettype none

interface svt_req_if #(
   parameter int COORD_BITS = 20,
   parameter int ANGLE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] observer_x;
   logic signed [COORD_BITS-1:0] observer_z;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_z;
   logic [ANGLE_BITS-1:0]        heading;
   logic [ANGLE_BITS-1:0]        view_angle;
   logic [COORD_BITS-2:0]        range_radius;

   modport source (
      output valid, observer_x, observer_z, target_x, target_z,
             heading, view_angle, range_radius,
      input  ready
   );

   modport sink (
      input  valid, observer_x, observer_z, target_x, target_z,
             heading, view_angle, range_radius,
      output ready
   );
endinterface

interface svt_rsp_if #(
   parameter int COORD_BITS = 20
);
   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic [2*COORD_BITS+1:0]   dist_sq;

   modport source (
      output valid, hit, dist_sq,
      input  ready
   );

   modport sink (
      input  valid, hit, dist_sq,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/sector_view_test.sv =====
// Sector view test: for each transaction of observer point, target point, heading, view angle
// and range, returns the squared XZ distance and a hit flag that is set when the distance is
// below the squared range and the target lies strictly between the edges at heading plus and
// minus half the view angle. A new transaction is taken every cycle while req ready is high;
// the pipeline holds the three input stages, one rotation cell per CORDIC stage carrying both
// edges, and the rounding and multiply stages. An output register backed by one skid entry
// lets the pipeline keep taking transactions while a result waits; req ready drops only while
// that skid entry is occupied.
`default_nettype none

module sector_view_test #(
   parameter int COORD_BITS    = 20,
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   svt_req_if.sink     req_ch,
   svt_rsp_if.source   rsp_ch
);

   localparam int VW        = COORD_BITS + 1;
   localparam int DIST_W    = 2 * COORD_BITS + 2;
   localparam int PAYLOAD_W = 1 + DIST_W + 2 * VW;

   logic enable;

   logic               out_valid_ff, out_valid_in, out_hit_ff, out_hit_in;
   logic [DIST_W-1:0]  out_dist_ff, out_dist_in;
   logic               skid_full_ff, skid_full_in, skid_hit_ff, skid_hit_in;
   logic [DIST_W-1:0]  skid_dist_ff, skid_dist_in;
   logic               take;

   assign enable       = !skid_full_ff;
   assign req_ch.ready = enable;

   logic                          front_valid, front_in_range;
   svt_pkg::rotor_type            front_rotor_l, front_rotor_r;
   logic [DIST_W-1:0]             front_dist;
   logic signed [VW-1:0]          front_vx, front_vz;

   svt_front #(
      .COORD_BITS (COORD_BITS),
      .ANGLE_BITS (ANGLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .src_valid    (req_ch.valid),
      .observer_x   (req_ch.observer_x),
      .observer_z   (req_ch.observer_z),
      .target_x     (req_ch.target_x),
      .target_z     (req_ch.target_z),
      .heading      (req_ch.heading),
      .view_angle   (req_ch.view_angle),
      .range_radius (req_ch.range_radius),
      .dst_valid    (front_valid),
      .dst_rotor_l  (front_rotor_l),
      .dst_rotor_r  (front_rotor_r),
      .dst_in_range (front_in_range),
      .dst_dist     (front_dist),
      .dst_vx       (front_vx),
      .dst_vz       (front_vz)
   );

   logic                  chain_valid   [CORDIC_STAGES+1];
   svt_pkg::rotor_type    chain_rotor_l [CORDIC_STAGES+1];
   svt_pkg::rotor_type    chain_rotor_r [CORDIC_STAGES+1];
   logic [PAYLOAD_W-1:0]  chain_payload [CORDIC_STAGES+1];

   assign chain_valid[0]   = front_valid;
   assign chain_rotor_l[0] = front_rotor_l;
   assign chain_rotor_r[0] = front_rotor_r;
   assign chain_payload[0] = {front_in_range, front_dist, front_vx, front_vz};

   generate
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
         svt_cordic_cell #(
            .STAGE     (i),
            .PAYLOAD_W (PAYLOAD_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .enable      (enable),
            .src_valid   (chain_valid[i]),
            .src_rotor_l (chain_rotor_l[i]),
            .src_rotor_r (chain_rotor_r[i]),
            .src_payload (chain_payload[i]),
            .dst_valid   (chain_valid[i+1]),
            .dst_rotor_l (chain_rotor_l[i+1]),
            .dst_rotor_r (chain_rotor_r[i+1]),
            .dst_payload (chain_payload[i+1])
         );
      end
   endgenerate

   logic [PAYLOAD_W-1:0] tail;
   logic                 back_valid, back_hit;
   logic [DIST_W-1:0]    back_dist;

   assign tail = chain_payload[CORDIC_STAGES];

   svt_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .src_valid    (chain_valid[CORDIC_STAGES]),
      .src_rotor_l  (chain_rotor_l[CORDIC_STAGES]),
      .src_rotor_r  (chain_rotor_r[CORDIC_STAGES]),
      .src_in_range (tail[PAYLOAD_W-1]),
      .src_dist     (tail[PAYLOAD_W-2 -: DIST_W]),
      .src_vx       ($signed(tail[2*VW-1 -: VW])),
      .src_vz       ($signed(tail[VW-1:0])),
      .dst_valid    (back_valid),
      .dst_hit      (back_hit),
      .dst_dist     (back_dist)
   );

   assign take = out_valid_ff && rsp_ch.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_hit_in   = out_hit_ff;
      out_dist_in  = out_dist_ff;
      skid_full_in = skid_full_ff;
      skid_hit_in  = skid_hit_ff;
      skid_dist_in = skid_dist_ff;
      if (skid_full_ff) begin
         if (take) begin
            out_hit_in   = skid_hit_ff;
            out_dist_in  = skid_dist_ff;
            skid_full_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = back_valid;
         out_hit_in   = back_hit;
         out_dist_in  = back_dist;
      end else if (back_valid) begin
         skid_full_in = 1'b1;
         skid_hit_in  = back_hit;
         skid_dist_in = back_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_full_ff <= skid_full_in;
      end
      out_hit_ff   <= out_hit_in;
      out_dist_ff  <= out_dist_in;
      skid_hit_ff  <= skid_hit_in;
      skid_dist_ff <= skid_dist_in;
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.hit     = out_hit_ff;
   assign rsp_ch.dist_sq = out_dist_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid entry occupied while output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && rsp_ch.ready |=> !skid_full_ff)
      else $error("skid entry not released after transaction");

   a_hit_off_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.hit |-> rsp_ch.dist_sq != '0)
      else $error("hit reported for target at observer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !skid_full_ff)
      else $error("output stage not empty after reset");

endmodule

`default_nettype wire

// ===== sv/svt_front.sv =====
`default_nettype none

module svt_front #(
   parameter int COORD_BITS = 20,
   parameter int ANGLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  logic                               src_valid,
   input  logic signed [COORD_BITS-1:0]       observer_x,
   input  logic signed [COORD_BITS-1:0]       observer_z,
   input  logic signed [COORD_BITS-1:0]       target_x,
   input  logic signed [COORD_BITS-1:0]       target_z,
   input  logic [ANGLE_BITS-1:0]              heading,
   input  logic [ANGLE_BITS-1:0]              view_angle,
   input  logic [COORD_BITS-2:0]              range_radius,
   output logic                               dst_valid,
   output svt_pkg::rotor_type                 dst_rotor_l,
   output svt_pkg::rotor_type                 dst_rotor_r,
   output logic                               dst_in_range,
   output logic [2*COORD_BITS+1:0]            dst_dist,
   output logic signed [COORD_BITS:0]         dst_vx,
   output logic signed [COORD_BITS:0]         dst_vz
);

   localparam int VW     = COORD_BITS + 1;
   localparam int SQ_W   = 2 * COORD_BITS;
   localparam int SUM_W  = 2 * COORD_BITS + 1;
   localparam int DIST_W = 2 * COORD_BITS + 2;
   localparam int RSQ_W  = 2 * COORD_BITS - 2;
   localparam int RW     = svt_pkg::ROT_W;

   function automatic svt_pkg::rotor_type rotor_init(input logic [ANGLE_BITS-1:0] ang);
      logic [31:0]        t;
      svt_pkg::rotor_type r;
      t      = {ang, {(32-ANGLE_BITS){1'b0}}};
      r.flip = t[31] ^ t[30];
      r.x    = svt_pkg::CORDIC_GAIN;
      r.y    = '0;
      r.z    = {{(RW-31){t[30]}}, t[30:0]};
      return r;
   endfunction

   // stage 1: difference vector and edge angles
   logic                    v1_ff;
   logic signed [VW-1:0]    vx1_ff, vz1_ff, vx1_in, vz1_in;
   logic [ANGLE_BITS-1:0]   left1_ff, right1_ff, left1_in, right1_in, half;
   logic [COORD_BITS-2:0]   radius1_ff;

   always_comb begin
      vx1_in    = $signed({target_x[COORD_BITS-1], target_x})
                - $signed({observer_x[COORD_BITS-1], observer_x});
      vz1_in    = $signed({target_z[COORD_BITS-1], target_z})
                - $signed({observer_z[COORD_BITS-1], observer_z});
      half      = view_angle >> 1;
      left1_in  = heading + half;
      right1_in = heading - half;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= src_valid;
      end
      if (enable) begin
         vx1_ff     <= vx1_in;
         vz1_ff     <= vz1_in;
         left1_ff   <= left1_in;
         right1_ff  <= right1_in;
         radius1_ff <= range_radius;
      end
   end

   // stage 2: squares and rotor setup
   logic                    v2_ff;
   logic signed [2*VW-1:0]  sqx_full, sqz_full;
   logic [SQ_W-1:0]         sx2_ff, sz2_ff;
   logic [RSQ_W-1:0]        rsq2_ff, rsq2_in;
   logic signed [VW-1:0]    vx2_ff, vz2_ff;
   svt_pkg::rotor_type      rl2_ff, rr2_ff, rl2_in, rr2_in;

   always_comb begin
      sqx_full = vx1_ff * vx1_ff;
      sqz_full = vz1_ff * vz1_ff;
      rsq2_in  = radius1_ff * radius1_ff;
      rl2_in   = rotor_init(left1_ff);
      rr2_in   = rotor_init(right1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
      if (enable) begin
         sx2_ff  <= sqx_full[SQ_W-1:0];
         sz2_ff  <= sqz_full[SQ_W-1:0];
         rsq2_ff <= rsq2_in;
         vx2_ff  <= vx1_ff;
         vz2_ff  <= vz1_ff;
         rl2_ff  <= rl2_in;
         rr2_ff  <= rr2_in;
      end
   end

   // stage 3: distance sum and range check
   logic                    v3_ff, in_range3_ff, in_range3_in;
   logic [SUM_W-1:0]        sum3;
   logic [DIST_W-1:0]       dist3_ff, dist3_in;
   logic signed [VW-1:0]    vx3_ff, vz3_ff;
   svt_pkg::rotor_type      rl3_ff, rr3_ff;

   assign sum3 = {1'b0, sx2_ff} + {1'b0, sz2_ff};

   generate
      if (SUM_W > 64) begin : g_sat
         assign dist3_in = (|sum3[SUM_W-1:64]) ? {{(DIST_W-64){1'b0}}, {64{1'b1}}}
                                               : {1'b0, sum3};
      end else begin : g_nosat
         assign dist3_in = {1'b0, sum3};
      end
   endgenerate

   assign in_range3_in = dist3_in < {{(DIST_W-RSQ_W){1'b0}}, rsq2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (enable) begin
         v3_ff <= v2_ff;
      end
      if (enable) begin
         in_range3_ff <= in_range3_in;
         dist3_ff     <= dist3_in;
         vx3_ff       <= vx2_ff;
         vz3_ff       <= vz2_ff;
         rl3_ff       <= rl2_ff;
         rr3_ff       <= rr2_ff;
      end
   end

   assign dst_valid    = v3_ff;
   assign dst_rotor_l  = rl3_ff;
   assign dst_rotor_r  = rr3_ff;
   assign dst_in_range = in_range3_ff;
   assign dst_dist     = dist3_ff;
   assign dst_vx       = vx3_ff;
   assign dst_vz       = vz3_ff;

endmodule

`default_nettype wire

// ===== sv/svt_cordic_cell.sv =====
`default_nettype none

module svt_cordic_cell #(
   parameter int STAGE     = 0,
   parameter int PAYLOAD_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  src_valid,
   input  svt_pkg::rotor_type    src_rotor_l,
   input  svt_pkg::rotor_type    src_rotor_r,
   input  logic [PAYLOAD_W-1:0]  src_payload,
   output logic                  dst_valid,
   output svt_pkg::rotor_type    dst_rotor_l,
   output svt_pkg::rotor_type    dst_rotor_r,
   output logic [PAYLOAD_W-1:0]  dst_payload
);

   localparam int RW = svt_pkg::ROT_W;

   function automatic svt_pkg::rotor_type rotate(input svt_pkg::rotor_type r);
      logic signed [RW-1:0] xs, ys, a;
      svt_pkg::rotor_type   n;
      xs     = r.x >>> STAGE;
      ys     = r.y >>> STAGE;
      a      = {{(RW-32){1'b0}}, svt_pkg::ATAN_TURN[STAGE]};
      n.flip = r.flip;
      if (!r.z[RW-1]) begin
         n.x = r.x - ys;
         n.y = r.y + xs;
         n.z = r.z - a;
      end else begin
         n.x = r.x + ys;
         n.y = r.y - xs;
         n.z = r.z + a;
      end
      return n;
   endfunction

   logic                  valid_ff;
   svt_pkg::rotor_type    rotor_l_ff, rotor_r_ff, rotor_l_in, rotor_r_in;
   logic [PAYLOAD_W-1:0]  payload_ff;

   always_comb begin
      rotor_l_in = rotate(src_rotor_l);
      rotor_r_in = rotate(src_rotor_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= src_valid;
      end
      if (enable) begin
         rotor_l_ff <= rotor_l_in;
         rotor_r_ff <= rotor_r_in;
         payload_ff <= src_payload;
      end
   end

   assign dst_valid   = valid_ff;
   assign dst_rotor_l = rotor_l_ff;
   assign dst_rotor_r = rotor_r_ff;
   assign dst_payload = payload_ff;

endmodule

`default_nettype wire

// ===== sv/svt_back.sv =====
`default_nettype none

module svt_back #(
   parameter int COORD_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          src_valid,
   input  svt_pkg::rotor_type            src_rotor_l,
   input  svt_pkg::rotor_type            src_rotor_r,
   input  logic                          src_in_range,
   input  logic [2*COORD_BITS+1:0]       src_dist,
   input  logic signed [COORD_BITS:0]    src_vx,
   input  logic signed [COORD_BITS:0]    src_vz,
   output logic                          dst_valid,
   output logic                          dst_hit,
   output logic [2*COORD_BITS+1:0]       dst_dist
);

   localparam int VW      = COORD_BITS + 1;
   localparam int DIST_W  = 2 * COORD_BITS + 2;
   localparam int PROD_W  = VW + 16;
   localparam int CROSS_W = PROD_W + 1;
   localparam int RW      = svt_pkg::ROT_W;

   function automatic logic signed [15:0] to_q15(input logic signed [RW-1:0] v,
                                                  input logic flip);
      logic signed [RW:0]  w, r;
      logic signed [15:0]  q;
      w = flip ? -$signed({v[RW-1], v}) : $signed({v[RW-1], v});
      r = (w + (RW+1)'(16384)) >>> 15;
      if (r > 32767) begin
         q = 16'sh7FFF;
      end else if (r < -32768) begin
         q = 16'sh8000;
      end else begin
         q = r[15:0];
      end
      return q;
   endfunction

   // stage 1: round and saturate sine and cosine
   logic                   v1_ff, in_range1_ff;
   logic signed [15:0]     cos_l1_ff, sin_l1_ff, cos_r1_ff, sin_r1_ff;
   logic signed [15:0]     cos_l1_in, sin_l1_in, cos_r1_in, sin_r1_in;
   logic [DIST_W-1:0]      dist1_ff;
   logic signed [VW-1:0]   vx1_ff, vz1_ff;

   always_comb begin
      cos_l1_in = to_q15(src_rotor_l.x, src_rotor_l.flip);
      sin_l1_in = to_q15(src_rotor_l.y, src_rotor_l.flip);
      cos_r1_in = to_q15(src_rotor_r.x, src_rotor_r.flip);
      sin_r1_in = to_q15(src_rotor_r.y, src_rotor_r.flip);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= src_valid;
      end
      if (enable) begin
         cos_l1_ff    <= cos_l1_in;
         sin_l1_ff    <= sin_l1_in;
         cos_r1_ff    <= cos_r1_in;
         sin_r1_ff    <= sin_r1_in;
         in_range1_ff <= src_in_range;
         dist1_ff     <= src_dist;
         vx1_ff       <= src_vx;
         vz1_ff       <= src_vz;
      end
   end

   // stage 2: cross product terms
   logic                      v2_ff, in_range2_ff;
   logic signed [PROD_W-1:0]  lc2_ff, ls2_ff, rc2_ff, rs2_ff;
   logic signed [PROD_W-1:0]  lc2_in, ls2_in, rc2_in, rs2_in;
   logic [DIST_W-1:0]         dist2_ff;

   always_comb begin
      lc2_in = cos_l1_ff * vx1_ff;
      ls2_in = sin_l1_ff * vz1_ff;
      rc2_in = cos_r1_ff * vx1_ff;
      rs2_in = sin_r1_ff * vz1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (enable) begin
         v2_ff <= v1_ff;
      end
      if (enable) begin
         lc2_ff       <= lc2_in;
         ls2_ff       <= ls2_in;
         rc2_ff       <= rc2_in;
         rs2_ff       <= rs2_in;
         in_range2_ff <= in_range1_ff;
         dist2_ff     <= dist1_ff;
      end
   end

   logic signed [CROSS_W-1:0] cross_l, cross_r;

   always_comb begin
      cross_l = $signed({lc2_ff[PROD_W-1], lc2_ff}) - $signed({ls2_ff[PROD_W-1], ls2_ff});
      cross_r = $signed({rc2_ff[PROD_W-1], rc2_ff}) - $signed({rs2_ff[PROD_W-1], rs2_ff});
   end

   assign dst_valid = v2_ff;
   assign dst_hit   = in_range2_ff && cross_l[CROSS_W-1]
                    && !cross_r[CROSS_W-1] && (cross_r != '0);
   assign dst_dist  = dist2_ff;

endmodule

`default_nettype wire
